// File: sv/dca_pkg.sv
package dca_pkg;

    localparam int TABLE_ENTRIES       = 64;
    localparam int MAX_ENGINES         = 4;
    localparam int CHANNELS_PER_ENGINE = 32;

    // field widths of the transactions
    localparam int KEY_W  = 16;
    localparam int ENG_W  = 3;
    localparam int CH_W   = 5;
    localparam int CFG_W  = 5;
    localparam int CIDX_W = 3;

    // derived sizes
    localparam int IDX_W  = $clog2(TABLE_ENTRIES);
    localparam int CNT_W  = IDX_W + 1;
    localparam int NUM_CH = (CHANNELS_PER_ENGINE < (1 << CH_W)) ?
                            CHANNELS_PER_ENGINE : (1 << CH_W);
    localparam int CHI_W  = $clog2(NUM_CH);
    localparam int CH_MAX = NUM_CH - 1;
    localparam int EI_W   = (MAX_ENGINES > 1) ? $clog2(MAX_ENGINES) : 1;

    typedef struct packed {
        logic [KEY_W-1:0] key;
        logic             bnd;
        logic [ENG_W-1:0] eng;
        logic [CH_W-1:0]  ch;
    } t_entry;

    typedef enum logic [2:0] {
        S_IDLE,
        S_WALK,
        S_DECIDE,
        S_SCAN,
        S_DONE
    } t_state;

    typedef enum logic [2:0] {
        ST_OK         = 3'd0,
        ST_BAD_ENGINE = 3'd1,
        ST_ENH_DIR    = 3'd2,
        ST_ENG_MISM   = 3'd3,
        ST_NO_CHANNEL = 3'd4,
        ST_TABLE_FULL = 3'd5,
        ST_FREE_UNK   = 3'd6,
        ST_FREE_BND   = 3'd7
    } t_status;

    localparam logic [CIDX_W-1:0] CFG_ENGINE_COUNT = 3'd0;
    localparam logic [CIDX_W-1:0] CFG_H2D_LOW      = 3'd1;
    localparam logic [CIDX_W-1:0] CFG_H2D_HIGH     = 3'd2;
    localparam logic [CIDX_W-1:0] CFG_D2H_LOW      = 3'd3;
    localparam logic [CIDX_W-1:0] CFG_D2H_HIGH     = 3'd4;
    localparam logic [CIDX_W-1:0] CFG_ENH_LOW      = 3'd5;

endpackage

// File: sv/dma_channel_allocator.sv
// channel     direction  signals
// in          input      i_in_valid / o_in_stall, i_mode .. i_use_enhanced
// out         output     o_out_valid / i_out_stall, o_status .. o_was_bound
// cfg         input      i_cfg_we, i_cfg_idx, i_cfg_data (write only)
//
// one request at a time; a request walks the binding table through the entry ram,
// then on an allocate miss scans the channels from the low to the high bound;
// the walk rate is set by the single read port of the entry ram, one entry a cycle
// synchronous active-low reset clears the valid bits and the ever-used masks
// a finished result waits in the output register while o_out_valid is stalled;
// the next request is taken meanwhile and holds in its last step if still full
module dma_channel_allocator
    import dca_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    // request channel
    input  logic             i_in_valid,
    output logic             o_in_stall,
    input  logic             i_mode,
    input  logic [KEY_W-1:0] i_layer_key,
    input  logic             i_is_boundary,
    input  logic             i_to_host,
    input  logic [ENG_W-1:0] i_engine,
    input  logic             i_use_enhanced,
    // result channel
    output logic             o_out_valid,
    input  logic             i_out_stall,
    output logic [2:0]       o_status,
    output logic [1:0]       o_channel_engine,
    output logic [CH_W-1:0]  o_channel_number,
    output logic             o_was_bound,
    // configuration
    input  logic              i_cfg_we,
    input  logic [CIDX_W-1:0] i_cfg_idx,
    input  logic [CFG_W-1:0]  i_cfg_data
);

    // configuration registers
    logic [2:0]      r_engine_count;
    logic [CH_W-1:0] r_h2d_low, r_h2d_high, r_d2h_low, r_d2h_high, r_enh_low;

    // control state
    t_state r_state, n_state;
    logic                     r_out_valid, n_out_valid;
    logic [TABLE_ENTRIES-1:0] r_valid, n_valid;
    logic [NUM_CH-1:0]        r_ever [MAX_ENGINES];
    logic [NUM_CH-1:0]        n_ever [MAX_ENGINES];

    // request latched at accept
    logic             r_mode, r_bnd, r_to_host, r_enh;
    logic [KEY_W-1:0] r_key;
    logic [ENG_W-1:0] r_eng;

    // table walk
    logic [CNT_W-1:0] r_addr, n_addr;
    logic             r_chk_en, n_chk_en;
    logic [IDX_W-1:0] r_chk_idx, n_chk_idx;
    logic             r_hit, n_hit;
    logic [IDX_W-1:0] r_hit_idx, n_hit_idx;
    t_entry           r_hit_ent, n_hit_ent;
    logic             r_free, n_free;
    logic [IDX_W-1:0] r_free_idx, n_free_idx;
    logic [NUM_CH-1:0] r_held, n_held;

    // channel scan
    logic [CH_W:0]   r_ch, n_ch;
    logic [CH_W-1:0] r_hi, n_hi;

    // pending result and output register
    t_status         r_res_status, n_res_status;
    logic [1:0]      r_res_eng, n_res_eng;
    logic [CH_W-1:0] r_res_ch, n_res_ch;
    logic            r_res_bound, n_res_bound;
    t_status         r_o_status, n_o_status;
    logic [1:0]      r_o_eng, n_o_eng;
    logic [CH_W-1:0] r_o_ch, n_o_ch;
    logic            r_o_bound, n_o_bound;

    // entry ram
    logic             ram_we;
    logic [IDX_W-1:0] ram_waddr;
    t_entry           ram_wdata;
    logic [IDX_W-1:0] ram_raddr;
    t_entry           ram_rdata;

    logic in_accept;
    logic walk_issue;
    logic bad_engine;
    logic [CH_W-1:0] lo, hi;
    logic [EI_W-1:0] eng_idx;
    logic [CHI_W-1:0] ch_idx;

    assign in_accept  = i_in_valid && !o_in_stall;
    assign o_in_stall = (r_state != S_IDLE);
    assign walk_issue = (r_state == S_WALK) && (r_addr < CNT_W'(TABLE_ENTRIES));
    assign bad_engine = ({1'b0, r_eng} >= {1'b0, r_engine_count})
                     || ({1'b0, r_eng} >= (ENG_W + 1)'(MAX_ENGINES));
    assign eng_idx    = r_eng[EI_W-1:0];
    assign ch_idx     = r_ch[CHI_W-1:0];
    assign ram_raddr  = r_addr[IDX_W-1:0];

    dca_ram #(
        .WIDTH ($bits(t_entry)),
        .DEPTH (TABLE_ENTRIES)
    ) u_entry_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    // channel range of the request, high bound clamped to the engine size
    always_comb begin
        lo = r_to_host ? r_d2h_low  : r_h2d_low;
        hi = r_to_host ? r_d2h_high : r_h2d_high;
        if (r_bnd && r_enh) begin
            lo = r_enh_low;
        end
        if (hi > CH_W'(CH_MAX)) begin
            hi = CH_W'(CH_MAX);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_engine_count <= 3'd4;
            r_h2d_low      <= CH_W'(0);
            r_h2d_high     <= CH_W'(15);
            r_d2h_low      <= CH_W'(16);
            r_d2h_high     <= CH_W'(31);
            r_enh_low      <= CH_W'(28);
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_ENGINE_COUNT: r_engine_count <= i_cfg_data[2:0];
                CFG_H2D_LOW:      r_h2d_low      <= i_cfg_data;
                CFG_H2D_HIGH:     r_h2d_high     <= i_cfg_data;
                CFG_D2H_LOW:      r_d2h_low      <= i_cfg_data;
                CFG_D2H_HIGH:     r_d2h_high     <= i_cfg_data;
                CFG_ENH_LOW:      r_enh_low      <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // sequencer: walk the table, decide, scan channels, hand over the result
    always_comb begin
        n_state      = r_state;
        n_out_valid  = r_out_valid;
        n_valid      = r_valid;
        n_ever       = r_ever;
        n_addr       = r_addr;
        n_chk_en     = 1'b0;
        n_chk_idx    = r_addr[IDX_W-1:0];
        n_hit        = r_hit;
        n_hit_idx    = r_hit_idx;
        n_hit_ent    = r_hit_ent;
        n_free       = r_free;
        n_free_idx   = r_free_idx;
        n_held       = r_held;
        n_ch         = r_ch;
        n_hi         = r_hi;
        n_res_status = r_res_status;
        n_res_eng    = r_res_eng;
        n_res_ch     = r_res_ch;
        n_res_bound  = r_res_bound;
        n_o_status   = r_o_status;
        n_o_eng      = r_o_eng;
        n_o_ch       = r_o_ch;
        n_o_bound    = r_o_bound;
        ram_we       = 1'b0;
        ram_waddr    = r_free_idx;
        ram_wdata    = '{key: r_key, bnd: r_bnd, eng: r_eng, ch: r_ch[CH_W-1:0]};

        if (r_out_valid && !i_out_stall) begin
            n_out_valid = 1'b0;
        end

        unique case (r_state)
            S_IDLE: begin
                if (in_accept) begin
                    n_state      = S_WALK;
                    n_addr       = '0;
                    n_hit        = 1'b0;
                    n_free       = 1'b0;
                    n_held       = '0;
                    n_res_status = ST_OK;
                    n_res_eng    = '0;
                    n_res_ch     = '0;
                    n_res_bound  = 1'b0;
                end
            end
            S_WALK: begin
                if (walk_issue) begin
                    n_addr   = r_addr + CNT_W'(1);
                    n_chk_en = 1'b1;
                end
                // ram data belongs to the entry addressed last cycle
                if (r_chk_en) begin
                    if (r_valid[r_chk_idx]) begin
                        if (!r_hit && ram_rdata.key == r_key && ram_rdata.bnd == r_bnd) begin
                            n_hit     = 1'b1;
                            n_hit_idx = r_chk_idx;
                            n_hit_ent = ram_rdata;
                        end
                        if (ram_rdata.eng == r_eng
                            && {1'b0, ram_rdata.ch} < (CH_W + 1)'(NUM_CH)) begin
                            n_held[ram_rdata.ch[CHI_W-1:0]] = 1'b1;
                        end
                    end else if (!r_free) begin
                        n_free     = 1'b1;
                        n_free_idx = r_chk_idx;
                    end
                    if (r_chk_idx == IDX_W'(TABLE_ENTRIES - 1)) begin
                        n_state = S_DECIDE;
                    end
                end
            end
            S_DECIDE: begin
                n_state = S_DONE;
                if (r_mode) begin
                    if (!r_hit) begin
                        n_res_status = ST_FREE_UNK;
                    end else begin
                        n_res_eng   = r_hit_ent.eng[1:0];
                        n_res_ch    = r_hit_ent.ch;
                        n_res_bound = 1'b1;
                        if (r_hit_ent.bnd) begin
                            n_res_status = ST_FREE_BND;
                        end else begin
                            n_valid[r_hit_idx] = 1'b0;
                        end
                    end
                end else if (bad_engine) begin
                    n_res_status = ST_BAD_ENGINE;
                end else if (r_enh && !r_to_host) begin
                    n_res_status = ST_ENH_DIR;
                end else if (r_hit) begin
                    if (r_hit_ent.eng != r_eng) begin
                        n_res_status = ST_ENG_MISM;
                    end else begin
                        n_res_eng   = r_hit_ent.eng[1:0];
                        n_res_ch    = r_hit_ent.ch;
                        n_res_bound = 1'b1;
                    end
                end else begin
                    n_state = S_SCAN;
                    n_ch    = {1'b0, lo};
                    n_hi    = hi;
                end
            end
            S_SCAN: begin
                if (r_ch > {1'b0, r_hi}) begin
                    n_res_status = ST_NO_CHANNEL;
                    n_state      = S_DONE;
                end else if (r_held[ch_idx] || (r_bnd && r_ever[eng_idx][ch_idx])) begin
                    n_ch = r_ch + (CH_W + 1)'(1);
                end else if (!r_free) begin
                    n_res_status = ST_TABLE_FULL;
                    n_state      = S_DONE;
                end else begin
                    // new binding in the lowest free entry
                    ram_we              = 1'b1;
                    n_valid[r_free_idx] = 1'b1;
                    if (!r_bnd) begin
                        n_ever[eng_idx][ch_idx] = 1'b1;
                    end
                    n_res_eng = r_eng[1:0];
                    n_res_ch  = r_ch[CH_W-1:0];
                    n_state   = S_DONE;
                end
            end
            S_DONE: begin
                if (!r_out_valid || !i_out_stall) begin
                    n_out_valid = 1'b1;
                    n_o_status  = r_res_status;
                    n_o_eng     = r_res_eng;
                    n_o_ch      = r_res_ch;
                    n_o_bound   = r_res_bound;
                    n_state     = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
            r_valid     <= '0;
            r_chk_en    <= 1'b0;
            for (int e = 0; e < MAX_ENGINES; e++) begin
                r_ever[e] <= '0;
            end
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
            r_valid     <= n_valid;
            r_chk_en    <= n_chk_en;
            r_ever      <= n_ever;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_mode    <= i_mode;
            r_key     <= i_layer_key;
            r_bnd     <= i_is_boundary;
            r_to_host <= i_to_host;
            r_eng     <= i_engine;
            r_enh     <= i_use_enhanced;
        end
        r_addr       <= n_addr;
        r_chk_idx    <= n_chk_idx;
        r_hit        <= n_hit;
        r_hit_idx    <= n_hit_idx;
        r_hit_ent    <= n_hit_ent;
        r_free       <= n_free;
        r_free_idx   <= n_free_idx;
        r_held       <= n_held;
        r_ch         <= n_ch;
        r_hi         <= n_hi;
        r_res_status <= n_res_status;
        r_res_eng    <= n_res_eng;
        r_res_ch     <= n_res_ch;
        r_res_bound  <= n_res_bound;
        r_o_status   <= n_o_status;
        r_o_eng      <= n_o_eng;
        r_o_ch       <= n_o_ch;
        r_o_bound    <= n_o_bound;
    end

    assign o_out_valid      = r_out_valid;
    assign o_status         = r_o_status;
    assign o_channel_engine = r_o_eng;
    assign o_channel_number = r_o_ch;
    assign o_was_bound      = r_o_bound;

    // the scan only runs for an engine that passed the range check
    a_scan_engine: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SCAN) |-> ({1'b0, r_eng} < (ENG_W + 1)'(MAX_ENGINES)))
        else $error("channel scan on an out-of-range engine");

    // decision is taken only after every entry was checked
    a_walk_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DECIDE) |-> (r_addr == CNT_W'(TABLE_ENTRIES)))
        else $error("decision before the table walk finished");

    // a written entry becomes valid
    a_write_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ram_we |=> r_valid[$past(ram_waddr)])
        else $error("new binding not marked valid");

    // a refused boundary free always reports the existing binding
    a_free_bnd: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_status == ST_FREE_BND) |-> o_was_bound)
        else $error("boundary free without binding flag");

endmodule

// File: sv/dca_ram.sv
module dca_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// File: tb/sv/dma_channel_allocator_tb.sv
module dma_channel_allocator_tb;
    import dca_pkg::*;

    // generous bound on the whole run, in clock cycles
    localparam int CYCLE_LIMIT   = 1_000_000;
    // a request walks the table and scans the channels, so let that pass before a write
    localparam int SETTLE_CYCLES = TABLE_ENTRIES + 40;
    // receiver hold-off that backs the block up into its request channel
    localparam int LONG_HOLD     = 400;
    // boundary layers come from a small key pool since their bindings never go away
    localparam int BND_POOL      = 16;

    // request codes
    localparam logic MODE_ALLOC     = 1'b0;
    localparam logic MODE_FREE      = 1'b1;
    localparam logic LAYER_INTERNAL = 1'b0;
    localparam logic LAYER_BOUNDARY = 1'b1;
    localparam logic DIR_H2D        = 1'b0;
    localparam logic DIR_D2H        = 1'b1;

    typedef struct packed {
        logic             mode;
        logic [KEY_W-1:0] key;
        logic             bnd;
        logic             to_host;
        logic [ENG_W-1:0] eng;
        logic             enh;
    } t_request;

    typedef struct packed {
        t_status         status;
        logic [1:0]      eng;
        logic [CH_W-1:0] ch;
        logic            bound;
    } t_grant;

    // shadow of the binding table and the registers; predicts each grant at
    // request time and checks grants in order as they come out
    class channel_grant_board;
        bit                bound_valid [TABLE_ENTRIES];
        bit [KEY_W-1:0]    bound_key   [TABLE_ENTRIES];
        bit                bound_bnd   [TABLE_ENTRIES];
        bit [1:0]          bound_eng   [TABLE_ENTRIES];
        bit [CH_W-1:0]     bound_ch    [TABLE_ENTRIES];
        bit [NUM_CH-1:0]   internal_used [MAX_ENGINES];
        bit [2:0]          engine_count;
        bit [CFG_W-1:0]    h2d_lo, h2d_hi, d2h_lo, d2h_hi, enh_lo;
        t_grant            grants_due [$];
        int                errors;

        function new();
            engine_count = 3'd4;
            h2d_lo       = 5'd0;
            h2d_hi       = 5'd15;
            d2h_lo       = 5'd16;
            d2h_hi       = 5'd31;
            enh_lo       = 5'd28;
            errors       = 0;
        endfunction

        function void set_register(logic [CIDX_W-1:0] idx, logic [CFG_W-1:0] data);
            case (idx)
                CFG_ENGINE_COUNT: engine_count = data[2:0];
                CFG_H2D_LOW:      h2d_lo = data;
                CFG_H2D_HIGH:     h2d_hi = data;
                CFG_D2H_LOW:      d2h_lo = data;
                CFG_D2H_HIGH:     d2h_hi = data;
                CFG_ENH_LOW:      enh_lo = data;
                default: ;
            endcase
        endfunction

        function bit channel_taken(bit [1:0] eng, int c);
            for (int i = 0; i < TABLE_ENTRIES; i++)
                if (bound_valid[i] && bound_eng[i] == eng && bound_ch[i] == c)
                    return 1'b1;
            return 1'b0;
        endfunction

        function t_grant predict_grant(t_request r);
            t_grant g;
            int     hit, slot, lo, hi, c;
            g    = '{ST_OK, 2'd0, '0, 1'b0};
            hit  = -1;
            slot = -1;
            // walking downward leaves the lowest match and the lowest free entry
            for (int i = TABLE_ENTRIES - 1; i >= 0; i--) begin
                if (bound_valid[i] && bound_key[i] == r.key && bound_bnd[i] == r.bnd)
                    hit = i;
                if (!bound_valid[i])
                    slot = i;
            end

            if (r.mode == MODE_FREE) begin
                if (hit < 0) begin
                    g.status = ST_FREE_UNK;
                end else begin
                    g.eng   = bound_eng[hit];
                    g.ch    = bound_ch[hit];
                    g.bound = 1'b1;
                    // boundary bindings are refused; ever-used mask is never cleared
                    if (bound_bnd[hit])
                        g.status = ST_FREE_BND;
                    else
                        bound_valid[hit] = 1'b0;
                end
                return g;
            end

            if (r.eng >= engine_count || r.eng >= MAX_ENGINES) begin
                g.status = ST_BAD_ENGINE;
                return g;
            end
            if (r.enh && r.to_host == DIR_H2D) begin
                g.status = ST_ENH_DIR;
                return g;
            end
            if (hit >= 0) begin
                if (bound_eng[hit] != r.eng[1:0]) begin
                    g.status = ST_ENG_MISM;
                    return g;
                end
                g.eng   = bound_eng[hit];
                g.ch    = bound_ch[hit];
                g.bound = 1'b1;
                return g;
            end

            lo = (r.to_host == DIR_D2H) ? d2h_lo : h2d_lo;
            hi = (r.to_host == DIR_D2H) ? d2h_hi : h2d_hi;
            // enhanced low bound only applies to boundary layers
            if (r.bnd && r.enh)
                lo = enh_lo;
            if (hi > CHANNELS_PER_ENGINE - 1)
                hi = CHANNELS_PER_ENGINE - 1;
            c = lo;
            while (c <= hi && (channel_taken(r.eng[1:0], c) ||
                               (r.bnd && internal_used[r.eng[1:0]][c])))
                c++;
            if (c > hi) begin
                g.status = ST_NO_CHANNEL;
                return g;
            end
            if (slot < 0) begin
                g.status = ST_TABLE_FULL;
                return g;
            end

            bound_valid[slot] = 1'b1;
            bound_key[slot]   = r.key;
            bound_bnd[slot]   = r.bnd;
            bound_eng[slot]   = r.eng[1:0];
            bound_ch[slot]    = CH_W'(c);
            if (!r.bnd)
                internal_used[r.eng[1:0]][c] = 1'b1;
            g.eng = r.eng[1:0];
            g.ch  = CH_W'(c);
            return g;
        endfunction

        function void note_request(t_request r);
            grants_due.push_back(predict_grant(r));
        endfunction

        function void report(string field, int want, int got);
            errors++;
            $display("%0t: %s mismatch: expected %0d, got %0d", $time, field, want, got);
        endfunction

        function void check_grant(t_grant got);
            t_grant want;
            if (grants_due.size() == 0) begin
                errors++;
                $display("%0t: unexpected result: expected none, got status %0d %s %0d %0d %0d",
                         $time, got.status, "engine/channel/bound", got.eng, got.ch,
                         got.bound);
                return;
            end
            want = grants_due.pop_front();
            if (got.status !== want.status) report("status", want.status, got.status);
            if (got.eng !== want.eng)       report("channel_engine", want.eng, got.eng);
            if (got.ch !== want.ch)         report("channel_number", want.ch, got.ch);
            if (got.bound !== want.bound)   report("was_bound", want.bound, got.bound);
        endfunction
    endclass

    logic             i_clk;
    logic             i_rst_n;
    logic             i_in_valid;
    logic             o_in_stall;
    logic             i_mode;
    logic [KEY_W-1:0] i_layer_key;
    logic             i_is_boundary;
    logic             i_to_host;
    logic [ENG_W-1:0] i_engine;
    logic             i_use_enhanced;
    logic             o_out_valid;
    logic             i_out_stall;
    logic [2:0]       o_status;
    logic [1:0]       o_channel_engine;
    logic [CH_W-1:0]  o_channel_number;
    logic             o_was_bound;
    logic              i_cfg_we;
    logic [CIDX_W-1:0] i_cfg_idx;
    logic [CFG_W-1:0]  i_cfg_data;

    channel_grant_board board = new();

    // idling knobs: gap_pct is read only by the request driver,
    // stall_pct and hold_left by the result side
    int gap_pct;
    int stall_pct;
    int hold_left;
    int cycle_count = 0;

    dma_channel_allocator uut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_in_valid       (i_in_valid),
        .o_in_stall       (o_in_stall),
        .i_mode           (i_mode),
        .i_layer_key      (i_layer_key),
        .i_is_boundary    (i_is_boundary),
        .i_to_host        (i_to_host),
        .i_engine         (i_engine),
        .i_use_enhanced   (i_use_enhanced),
        .o_out_valid      (o_out_valid),
        .i_out_stall      (i_out_stall),
        .o_status         (o_status),
        .o_channel_engine (o_channel_engine),
        .o_channel_number (o_channel_number),
        .o_was_bound      (o_was_bound),
        .i_cfg_we         (i_cfg_we),
        .i_cfg_idx        (i_cfg_idx),
        .i_cfg_data       (i_cfg_data)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // run limit: a hung handshake ends here
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    // request side monitor: every accepted transaction gets its grant predicted
    always @(posedge i_clk) begin
        if (i_rst_n && i_in_valid && !o_in_stall)
            board.note_request(t_request'{i_mode, i_layer_key, i_is_boundary,
                                          i_to_host, i_engine, i_use_enhanced});
    end

    // result side: check accepted transactions, then pick the next stall value
    always @(posedge i_clk) begin : result_side
        t_grant got;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            got.status = t_status'(o_status);
            got.eng    = o_channel_engine;
            got.ch     = o_channel_number;
            got.bound  = o_was_bound;
            board.check_grant(got);
        end
        if (hold_left > 0) begin
            // long hold-off, counted down here
            i_out_stall <= 1'b1;
            hold_left   <= hold_left - 1;
        end else begin
            i_out_stall <= ($urandom_range(99) < stall_pct);
        end
    end

    // offer one request and wait for the block to take it;
    // the payload stays put while stalled
    task automatic send_request(input t_request r);
        while ($urandom_range(99) < gap_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid     <= 1'b1;
        i_mode         <= r.mode;
        i_layer_key    <= r.key;
        i_is_boundary  <= r.bnd;
        i_to_host      <= r.to_host;
        i_engine       <= r.eng;
        i_use_enhanced <= r.enh;
        @(posedge i_clk);
        while (o_in_stall)
            @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [CIDX_W-1:0] idx, input logic [CFG_W-1:0] data);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= data;
        board.set_register(idx, data);
        @(posedge i_clk);
    endtask

    // only called with the block idle
    task automatic program_ranges(input logic [CFG_W-1:0] engines, h2d_lo, h2d_hi,
                                  d2h_lo, d2h_hi, enh_lo);
        write_reg(CFG_ENGINE_COUNT, engines);
        write_reg(CFG_H2D_LOW, h2d_lo);
        write_reg(CFG_H2D_HIGH, h2d_hi);
        write_reg(CFG_D2H_LOW, d2h_lo);
        write_reg(CFG_D2H_HIGH, d2h_hi);
        write_reg(CFG_ENH_LOW, enh_lo);
        i_cfg_we <= 1'b0;
    endtask

    // drain: every grant back, then an idle wait of SETTLE_CYCLES
    task automatic settle();
        i_in_valid <= 1'b0;
        while (board.grants_due.size() != 0)
            @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // mostly well-formed traffic: pooled keys so lookups hit and frees find
    // bindings, engines mostly in range, enhanced mostly on device-to-host
    function automatic t_request random_request(int pool, int free_pct);
        t_request r;
        int       live;
        r.mode = ($urandom_range(99) < free_pct) ? MODE_FREE : MODE_ALLOC;
        r.bnd  = ($urandom_range(99) < 30) ? LAYER_BOUNDARY : LAYER_INTERNAL;
        if ($urandom_range(99) < 5)
            r.key = KEY_W'($urandom);
        else if (r.bnd == LAYER_BOUNDARY)
            r.key = KEY_W'($urandom_range(BND_POOL - 1) * 131 + 7);
        else
            r.key = KEY_W'($urandom_range(pool - 1) * 97 + 3);
        live = (board.engine_count < MAX_ENGINES) ? board.engine_count : MAX_ENGINES;
        if (live == 0 || $urandom_range(99) < 10)
            r.eng = ENG_W'($urandom_range(7));
        else
            r.eng = ENG_W'($urandom_range(live - 1));
        r.to_host = 1'($urandom_range(1));
        if (r.to_host == DIR_D2H)
            r.enh = ($urandom_range(99) < 40);
        else
            r.enh = ($urandom_range(99) < 5);
        return r;
    endfunction

    task automatic run_random(input int count, input int pool, input int free_pct,
                              input int gap, input int stall);
        gap_pct = gap;
        stall_pct <= stall;
        repeat (count) send_request(random_request(pool, free_pct));
    endtask

    initial begin
        i_rst_n        <= 1'b0;
        i_in_valid     <= 1'b0;
        i_mode         <= MODE_ALLOC;
        i_layer_key    <= '0;
        i_is_boundary  <= LAYER_INTERNAL;
        i_to_host      <= DIR_H2D;
        i_engine       <= '0;
        i_use_enhanced <= 1'b0;
        i_out_stall    <= 1'b0;
        i_cfg_we       <= 1'b0;
        i_cfg_idx      <= CFG_ENGINE_COUNT;
        i_cfg_data     <= '0;
        gap_pct         = 0;
        stall_pct      <= 0;
        hold_left      <= 0;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed transactions at reset settings
        send_request('{MODE_ALLOC, 16'h0000, LAYER_INTERNAL, DIR_H2D, 3'd0, 1'b0}); // first bind
        send_request('{MODE_ALLOC, 16'h0000, LAYER_INTERNAL, DIR_H2D, 3'd0, 1'b0}); // lookup hit
        send_request('{MODE_ALLOC, 16'h0000, LAYER_INTERNAL, DIR_H2D, 3'd1, 1'b0}); // engine mismatch
        send_request('{MODE_ALLOC, 16'h0001, LAYER_INTERNAL, DIR_H2D, 3'd4, 1'b0}); // past max engines
        send_request('{MODE_ALLOC, 16'h0001, LAYER_INTERNAL, DIR_D2H, 3'd7, 1'b1}); // top engine
        send_request('{MODE_ALLOC, 16'h0002, LAYER_BOUNDARY, DIR_H2D, 3'd0, 1'b1}); // enhanced to device
        // boundary skips the channel an internal layer already used
        send_request('{MODE_ALLOC, 16'h0000, LAYER_BOUNDARY, DIR_H2D, 3'd0, 1'b0});
        // enhanced boundary starts at the enhanced bound, internal ignores it
        send_request('{MODE_ALLOC, 16'hFFFF, LAYER_BOUNDARY, DIR_D2H, 3'd3, 1'b1});
        send_request('{MODE_ALLOC, 16'hFFFF, LAYER_INTERNAL, DIR_D2H, 3'd3, 1'b1});
        send_request('{MODE_FREE,  16'h0000, LAYER_BOUNDARY, DIR_H2D, 3'd0, 1'b0}); // refused
        send_request('{MODE_FREE,  16'h0000, LAYER_INTERNAL, DIR_H2D, 3'd0, 1'b0}); // freed
        send_request('{MODE_FREE,  16'h0000, LAYER_INTERNAL, DIR_H2D, 3'd0, 1'b0}); // unknown
        // freed channel stays ever-used for boundary layers
        send_request('{MODE_ALLOC, 16'h0005, LAYER_BOUNDARY, DIR_H2D, 3'd0, 1'b0});
        // free ignores engine, direction and enhanced
        send_request('{MODE_FREE,  16'hFFFF, LAYER_INTERNAL, DIR_D2H, 3'd7, 1'b1});
        send_request('{MODE_ALLOC, 16'h0000, LAYER_INTERNAL, DIR_H2D, 3'd0, 1'b0}); // rebind
        send_request('{MODE_ALLOC, 16'h0001, LAYER_INTERNAL, DIR_H2D, 3'd3, 1'b0});
        settle();

        // reset ranges written back, no idling
        program_ranges(5'd4, 5'd0, 5'd15, 5'd16, 5'd31, 5'd28);
        run_random(250, 40, 30, 0, 0);
        settle();

        // two engines, enhanced bound at zero, sender idling
        program_ranges(5'd2, 5'd0, 5'd7, 5'd8, 5'd31, 5'd0);
        run_random(200, 40, 30, 54, 0);
        settle();

        // count above max engines, single channel one way, empty range the other
        program_ranges(5'd7, 5'd31, 5'd31, 5'd5, 5'd0, 5'd31);
        run_random(150, 24, 30, 0, 54);
        settle();

        // zero engines: every allocate is rejected, frees still work
        program_ranges(5'd0, 5'd0, 5'd31, 5'd31, 5'd31, 5'd31);
        run_random(40, 40, 50, 27, 27);
        settle();

        // one engine, empty host-to-device range
        program_ranges(5'd1, 5'd12, 5'd3, 5'd16, 5'd31, 5'd20);
        run_random(160, 40, 40, 27, 27);
        settle();

        // full ranges and a wide key pool so the table fills up;
        // starts with a long receiver hold-off while requests keep coming
        program_ranges(5'd4, 5'd0, 5'd31, 5'd0, 5'd31, 5'd0);
        hold_left <= LONG_HOLD;
        run_random(300, 200, 10, 27, 27);
        settle();

        if (board.errors == 0 && board.grants_due.size() == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule

// File: files.f
sv/dca_pkg.sv
sv/dca_ram.sv
sv/dma_channel_allocator.sv
tb/sv/dma_channel_allocator_tb.sv
